[src/bpc_pkg.sv]
`timescale 1ns / 1ps

package bpc_pkg;

   // register indexes on the csr port
   typedef enum logic [0:0] {
      REG_LONG_PRESS_TICKS = 1'b0,
      REG_SHORT_HOLD_TICKS = 1'b1
   } csr_index_type;

   localparam int CSR_DATA_WIDTH = 8;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [CSR_DATA_WIDTH-1:0] LONG_PRESS_RESET = 8'd150;
   localparam logic [CSR_DATA_WIDTH-1:0] SHORT_HOLD_RESET = 8'd50;

   // configuration seen by the core
   typedef struct packed {
      logic [CSR_DATA_WIDTH-1:0] long_press_ticks;
      logic [CSR_DATA_WIDTH-1:0] short_hold_ticks;
   } cfg_type;

   // one result item
   typedef struct packed {
      logic press_edge;
      logic short_release;
      logic long_held;
      logic long_held_edge;
      logic short_held;
      logic short_held_edge;
   } result_type;

endpackage

[src/bpc_csr.sv]
`timescale 1ns / 1ps

module bpc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [bpc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bpc_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   output bpc_pkg::cfg_type                    cfg
);

   bpc_pkg::cfg_type cfg_ff;
   bpc_pkg::cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (bpc_pkg::csr_index_type'(csr_index))
            bpc_pkg::REG_LONG_PRESS_TICKS: cfg_in.long_press_ticks = csr_write_data;
            bpc_pkg::REG_SHORT_HOLD_TICKS: cfg_in.short_hold_ticks = csr_write_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ticks <= bpc_pkg::LONG_PRESS_RESET;
         cfg_ff.short_hold_ticks <= bpc_pkg::SHORT_HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/bpc_core.sv]
`timescale 1ns / 1ps

module bpc_core #(
   parameter int COUNT_WIDTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 pin_level,
   input  bpc_pkg::cfg_type     cfg,
   output bpc_pkg::result_type  result
);

   localparam int CW = bpc_pkg::CSR_DATA_WIDTH;
   localparam int WIDE = (COUNT_WIDTH > CW) ? COUNT_WIDTH : CW;
   localparam logic [WIDE-1:0] COUNT_MAX = WIDE'({COUNT_WIDTH{1'b1}});

   logic                   previous_sample_ff, previous_sample_in;
   logic                   debounced_level_ff, debounced_level_in;
   logic [COUNT_WIDTH-1:0] hold_count_ff, hold_count_in;
   logic                   release_flag_ff, release_flag_in;
   logic                   long_flag_ff, long_flag_in;
   logic                   short_flag_ff, short_flag_in;

   logic            level;
   logic [WIDE-1:0] hold_wide;
   logic [WIDE-1:0] long_wide;
   logic [WIDE-1:0] limit;

   // debounce: pressed only when two matching high samples
   assign level = pin_level & (pin_level == previous_sample_ff);

   // long limit clipped to what the counter can hold
   assign hold_wide = WIDE'(hold_count_ff);
   assign long_wide = WIDE'(cfg.long_press_ticks);
   assign limit     = (long_wide < COUNT_MAX) ? long_wide : COUNT_MAX;

   // per-item state update
   always_comb begin
      previous_sample_in = pin_level;
      debounced_level_in = level;
      hold_count_in      = hold_count_ff;
      release_flag_in    = release_flag_ff;
      long_flag_in       = long_flag_ff;
      short_flag_in      = short_flag_ff;
      if (level) begin
         if (hold_wide < limit) begin
            hold_count_in = hold_count_ff + COUNT_WIDTH'(1);
         end else begin
            long_flag_in = 1'b1;
         end
         // short threshold is checked against the updated count
         if (WIDE'(hold_count_in) > WIDE'(cfg.short_hold_ticks)) begin
            short_flag_in = 1'b1;
         end
      end else begin
         release_flag_in = (hold_count_ff != '0) && (hold_wide < limit);
         hold_count_in   = '0;
         long_flag_in    = 1'b0;
         short_flag_in   = 1'b0;
      end
   end

   // result of the item being taken this cycle
   always_comb begin
      result.press_edge      = level & ~debounced_level_ff;
      result.short_release   = release_flag_in;
      result.long_held       = long_flag_in;
      result.long_held_edge  = long_flag_in & ~long_flag_ff;
      result.short_held      = short_flag_in;
      result.short_held_edge = short_flag_in & ~short_flag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_sample_ff <= 1'b0;
         debounced_level_ff <= 1'b0;
         hold_count_ff      <= '0;
         release_flag_ff    <= 1'b0;
         long_flag_ff       <= 1'b0;
         short_flag_ff      <= 1'b0;
      end else if (step) begin
         previous_sample_ff <= previous_sample_in;
         debounced_level_ff <= debounced_level_in;
         hold_count_ff      <= hold_count_in;
         release_flag_ff    <= release_flag_in;
         long_flag_ff       <= long_flag_in;
         short_flag_ff      <= short_flag_in;
      end
   end

endmodule

[src/button_press_classifier_unit.sv]
`timescale 1ns / 1ps

// Button debounce with short and long press detection. Each req item is one
// sampling tick of the raw pin; each produces exactly one rsp item of six
// flags. Each item takes a single state update into the result register,
// and a new item is taken every cycle while the result register is empty
// or being drained. Thresholds must be written on the csr port (index 0 long
// press ticks, index 1 short hold ticks) only while no item is in flight,
// unenforced by the block; long limit clipped to the hold counter's maximum.
module button_press_classifier_unit #(
   parameter int COUNT_WIDTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [bpc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bpc_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_pin_level,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_press_edge,
   output logic                                rsp_short_release,
   output logic                                rsp_long_held,
   output logic                                rsp_long_held_edge,
   output logic                                rsp_short_held,
   output logic                                rsp_short_held_edge
);

   bpc_pkg::cfg_type    cfg;
   bpc_pkg::result_type result;
   bpc_pkg::result_type result_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                step;

   bpc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // accept while the result register is free or emptying
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign step      = req_valid & req_ready;

   bpc_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .pin_level (req_pin_level),
      .cfg       (cfg),
      .result    (result)
   );

   // result register
   assign rsp_valid_in = step | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         result_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_press_edge      = result_ff.press_edge;
   assign rsp_short_release   = result_ff.short_release;
   assign rsp_long_held       = result_ff.long_held;
   assign rsp_long_held_edge  = result_ff.long_held_edge;
   assign rsp_short_held      = result_ff.short_held;
   assign rsp_short_held_edge = result_ff.short_held_edge;

   // an accepted item always shows up in the next cycle
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("accepted item did not reach the result register");

   // edges only with their held flag
   a_long_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.long_held_edge |-> result_ff.long_held)
      else $error("long edge without long held");

   a_short_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.short_held_edge |-> result_ff.short_held)
      else $error("short edge without short held");

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("result valid after reset");

endmodule
